>>> design/spi_master_word_transfer_core_macros.svh
// assertion macros for the spi master design files
`ifndef SPI_MASTER_WORD_TRANSFER_CORE_MACROS_SVH
`define SPI_MASTER_WORD_TRANSFER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPIM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spim assertion failed");

// next-cycle implication, checked out of reset
`define SPIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spim assertion failed");

`endif

>>> design/spim_pkg.sv
// types, constants and helpers for the spi master word transfer core
package spim_pkg;

    localparam int DIV_BITS      = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = DIV_BITS;
    localparam int WORD_BITS     = 32;
    localparam int CNT_BITS      = 6;
    localparam int POS_BITS      = 5;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_WORD_SIZE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LSB_FIRST  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLK_DIV    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLK_MODE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IRQ_ENABLE = 3'd5;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_START   = 2'd1,
        OP_SET_CS  = 2'd2,
        OP_CLR_IRQ = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        QTR_0 = 2'd0,
        QTR_1 = 2'd1,
        QTR_2 = 2'd2,
        QTR_3 = 2'd3
    } t_quarter;

    typedef struct packed {
        logic                 sclk_level;
        logic                 mosi_level;
        logic                 cs_out;
        logic                 busy_res;
        logic [WORD_BITS-1:0] rx_word;
        logic                 irq_flag;
    } t_result;

    // bit count of a transfer: 8, 16, 24 or 32
    function automatic logic [CNT_BITS-1:0] word_len(input logic [1:0] ws);
        return {1'b0, ws, 3'b000} + CNT_BITS'(8);
    endfunction

    // mosi level for the bit about to go out
    function automatic logic mosi_bit(
        input logic [WORD_BITS-1:0] tx,
        input logic [1:0]           dir,
        input logic [CNT_BITS-1:0]  left,
        input logic                 lsb,
        input logic [CNT_BITS-1:0]  len
    );
        logic [CNT_BITS-1:0] idx;
        idx = lsb ? (len - left) : (left - CNT_BITS'(1));
        if (!dir[0] || left == '0) begin
            return 1'b0;
        end
        return tx[idx[POS_BITS-1:0]];
    endfunction

endpackage

>>> design/spi_master_word_transfer_core.sv
// spi master word transfer core: one clock tick or command per transaction
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | operation, direction, tx_word, cs, miso
//  out     | output    | o_out_valid / i_out_stall | sclk, mosi, cs, busy, rx_word, irq
//  cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// one transaction per cycle unless the input stalls: the pin state updates in a single pass at acceptance
// results sit in a two-entry output buffer, so input stalls only when both entries wait
// a transaction's result enters the output buffer when it is accepted, behind any result still waiting
// i_rst_n is synchronous, active low; chip select resets high, buffer entries are not reset, everything else low
`include "spi_master_word_transfer_core_macros.svh"

module spi_master_word_transfer_core import spim_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_operation,
    input  logic [1:0]               i_direction,
    input  logic [WORD_BITS-1:0]     i_tx_word,
    input  logic                     i_cs_level,
    input  logic                     i_miso_bit,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_sclk_level,
    output logic                     o_mosi_level,
    output logic                     o_cs_out,
    output logic                     o_busy_res,
    output logic [WORD_BITS-1:0]     o_rx_word,
    output logic                     o_irq_flag
);

    // configuration registers
    logic [1:0]          r_word_size;
    logic                r_lsb_first;
    logic [DIV_BITS-1:0] r_clock_divider;
    logic [1:0]          r_clock_mode;
    logic                r_enable;
    logic                r_irq_enable;

    // transfer state
    logic [DIV_BITS-1:0]  r_prescale, n_prescale;
    t_quarter             r_quarter, n_quarter;
    logic [CNT_BITS-1:0]  r_bits_left, n_bits_left;
    logic [WORD_BITS-1:0] r_tx_shift, n_tx_shift;
    logic [WORD_BITS-1:0] r_rx_shift, n_rx_shift;
    logic [1:0]           r_active_dir, n_active_dir;
    logic                 r_busy, n_busy;
    logic                 r_cs, n_cs;
    logic                 r_irq, n_irq;
    logic                 r_sclk, n_sclk;
    logic                 r_mosi, n_mosi;

    // output buffer
    t_result              r_q [2];
    logic [1:0]           r_count;
    t_result              n_result;

    logic                 in_acc;
    logic                 out_acc;
    logic [1:0]           wr_slot;
    t_op                  op;
    logic [CNT_BITS-1:0]  len;
    logic                 idle_lvl;
    logic                 first_edge_samples;
    logic [POS_BITS-1:0]  rx_pos;
    logic [CNT_BITS-1:0]  msb_pos;

    assign o_in_stall  = (r_count == 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign wr_slot     = r_count - {1'b0, out_acc};

    assign op                 = t_op'(i_operation);
    assign len                = word_len(r_word_size);
    assign idle_lvl           = r_clock_mode[1];
    assign first_edge_samples = (r_clock_mode == 2'd0) || (r_clock_mode == 2'd3);
    assign msb_pos            = CNT_BITS'(63) - len + r_bits_left;
    assign rx_pos             = r_lsb_first ? (~r_bits_left[POS_BITS-1:0] + POS_BITS'(1))
                                            : msb_pos[POS_BITS-1:0];

    always_comb begin
        n_prescale   = r_prescale;
        n_quarter    = r_quarter;
        n_bits_left  = r_bits_left;
        n_tx_shift   = r_tx_shift;
        n_rx_shift   = r_rx_shift;
        n_active_dir = r_active_dir;
        n_busy       = r_busy;
        n_cs         = r_cs;
        n_irq        = r_irq;
        n_sclk       = r_sclk;
        n_mosi       = r_mosi;

        case (op)
            OP_CLR_IRQ: n_irq = 1'b0;
            OP_SET_CS:  n_cs  = i_cs_level;
            default:    ;
        endcase

        if (r_busy) begin
            if (r_prescale < r_clock_divider) begin
                n_prescale = r_prescale + DIV_BITS'(1);
            end else begin
                n_prescale = '0;
                n_quarter  = t_quarter'(r_quarter + 2'd1);
                case (n_quarter)
                    QTR_1: begin
                        n_sclk = ~idle_lvl;
                        if (first_edge_samples && r_active_dir[1]) begin
                            n_rx_shift[rx_pos] = i_miso_bit;
                        end
                    end
                    QTR_3: begin
                        n_sclk = idle_lvl;
                        if (!first_edge_samples && r_active_dir[1]) begin
                            n_rx_shift[rx_pos] = i_miso_bit;
                        end
                    end
                    QTR_0: begin
                        n_bits_left = r_bits_left - CNT_BITS'(1);
                        if (n_bits_left == '0) begin
                            n_busy = 1'b0;
                            n_mosi = 1'b0;
                            if (r_irq_enable) begin
                                n_irq = 1'b1;
                            end
                        end else begin
                            n_mosi = mosi_bit(r_tx_shift, r_active_dir, n_bits_left,
                                              r_lsb_first, len);
                        end
                    end
                    default: ;
                endcase
            end
        end else begin
            n_sclk = idle_lvl;
            if (op == OP_START && r_enable) begin
                n_tx_shift   = i_tx_word;
                n_rx_shift   = '0;
                n_active_dir = i_direction;
                n_bits_left  = len;
                n_prescale   = '0;
                n_quarter    = QTR_0;
                n_busy       = 1'b1;
                n_mosi       = mosi_bit(i_tx_word, i_direction, len, r_lsb_first, len);
            end
        end

        n_result.sclk_level = n_sclk;
        n_result.mosi_level = n_mosi;
        n_result.cs_out     = n_cs;
        n_result.busy_res   = n_busy;
        n_result.rx_word    = n_rx_shift;
        n_result.irq_flag   = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_size     <= '0;
            r_lsb_first     <= 1'b0;
            r_clock_divider <= '0;
            r_clock_mode    <= '0;
            r_enable        <= 1'b0;
            r_irq_enable    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WORD_SIZE:  r_word_size     <= i_cfg_data[1:0];
                CFG_LSB_FIRST:  r_lsb_first     <= i_cfg_data[0];
                CFG_CLK_DIV:    r_clock_divider <= i_cfg_data[DIV_BITS-1:0];
                CFG_CLK_MODE:   r_clock_mode    <= i_cfg_data[1:0];
                CFG_ENABLE:     r_enable        <= i_cfg_data[0];
                CFG_IRQ_ENABLE: r_irq_enable    <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale   <= '0;
            r_quarter    <= QTR_0;
            r_bits_left  <= '0;
            r_tx_shift   <= '0;
            r_rx_shift   <= '0;
            r_active_dir <= '0;
            r_busy       <= 1'b0;
            r_cs         <= 1'b1;
            r_irq        <= 1'b0;
            r_sclk       <= 1'b0;
            r_mosi       <= 1'b0;
        end else if (in_acc) begin
            r_prescale   <= n_prescale;
            r_quarter    <= n_quarter;
            r_bits_left  <= n_bits_left;
            r_tx_shift   <= n_tx_shift;
            r_rx_shift   <= n_rx_shift;
            r_active_dir <= n_active_dir;
            r_busy       <= n_busy;
            r_cs         <= n_cs;
            r_irq        <= n_irq;
            r_sclk       <= n_sclk;
            r_mosi       <= n_mosi;
        end
    end

    // two-entry output buffer, head in slot 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !wr_slot[0]) begin
            r_q[0] <= n_result;
        end else if (out_acc) begin
            r_q[0] <= r_q[1];
        end
        if (in_acc && wr_slot[0]) begin
            r_q[1] <= n_result;
        end
    end

    assign o_sclk_level = r_q[0].sclk_level;
    assign o_mosi_level = r_q[0].mosi_level;
    assign o_cs_out     = r_q[0].cs_out;
    assign o_busy_res   = r_q[0].busy_res;
    assign o_rx_word    = r_q[0].rx_word;
    assign o_irq_flag   = r_q[0].irq_flag;

    `SPIM_ASSERT_SAME(a_busy_has_bits, i_clk, i_rst_n, r_busy, r_bits_left != '0)
    `SPIM_ASSERT_SAME(a_idle_no_bits, i_clk, i_rst_n, !r_busy, r_bits_left == '0)
    `SPIM_ASSERT_NEXT(a_buf_grows, i_clk, i_rst_n, in_acc && !out_acc,
                      r_count == $past(r_count) + 2'd1)
    `SPIM_ASSERT_NEXT(a_buf_shrinks, i_clk, i_rst_n, out_acc && !in_acc,
                      r_count == $past(r_count) - 2'd1)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the spi master word transfer core
module testbench;
    import spim_pkg::*;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_BOTH  = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 250;
    localparam int HOLD_AT        = 250;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_PRINTS     = 40;

    typedef struct packed {
        t_op                  op;
        logic [1:0]           dir;
        logic [WORD_BITS-1:0] tx;
        logic                 cs;
        logic                 miso;
    } t_spi_cmd;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_operation = 2'd0;
    logic [1:0]               i_direction = 2'd0;
    logic [WORD_BITS-1:0]     i_tx_word   = '0;
    logic                     i_cs_level  = 1'b0;
    logic                     i_miso_bit  = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_sclk_level;
    logic                     o_mosi_level;
    logic                     o_cs_out;
    logic                     o_busy_res;
    logic [WORD_BITS-1:0]     o_rx_word;
    logic                     o_irq_flag;

    spi_master_word_transfer_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_direction  (i_direction),
        .i_tx_word    (i_tx_word),
        .i_cs_level   (i_cs_level),
        .i_miso_bit   (i_miso_bit),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sclk_level (o_sclk_level),
        .o_mosi_level (o_mosi_level),
        .o_cs_out     (o_cs_out),
        .o_busy_res   (o_busy_res),
        .o_rx_word    (o_rx_word),
        .o_irq_flag   (o_irq_flag)
    );

    always #4 i_clk = ~i_clk;

    // configuration copy
    logic [1:0]           cfg_ws;
    logic                 cfg_lsb;
    logic [DIV_BITS-1:0]  cfg_div;
    logic [1:0]           cfg_mode;
    logic                 cfg_en;
    logic                 cfg_irq_en;

    // shifter and pin state
    logic [DIV_BITS-1:0]  pre_cnt;
    t_quarter             qtr;
    logic [CNT_BITS-1:0]  bits_left;
    logic [WORD_BITS-1:0] tx_sr;
    logic [WORD_BITS-1:0] rx_sr;
    logic [1:0]           xfer_dir;
    logic                 busy;
    logic                 cs_pin;
    logic                 irq_pend;
    logic                 sclk_pin;
    logic                 mosi_pin;

    t_spi_cmd cmd_q[$];
    t_result  pin_expect_q[$];
    t_spi_cmd cur_cmd;
    t_result  want_pins;

    int  queued_count  = 0;
    int  results_seen  = 0;
    int  fail_count    = 0;
    int  drv_gap       = 0;
    int  rcv_gap       = 0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;
    bit  no_idle       = 1'b0;
    bit  held          = 1'b0;

    function automatic void pins_reset();
        cfg_ws = '0; cfg_lsb = 1'b0; cfg_div = '0; cfg_mode = '0;
        cfg_en = 1'b0; cfg_irq_en = 1'b0;
        pre_cnt = '0; qtr = QTR_0; bits_left = '0; tx_sr = '0; rx_sr = '0;
        xfer_dir = '0; busy = 1'b0; cs_pin = 1'b1; irq_pend = 1'b0;
        sclk_pin = 1'b0; mosi_pin = 1'b0;
    endfunction

    function automatic logic [CNT_BITS-1:0] xfer_bits();
        return CNT_BITS'(8 * (int'(cfg_ws) + 1));
    endfunction

    function automatic void pick_mosi();
        logic [CNT_BITS-1:0] idx;
        if (!xfer_dir[0] || bits_left == '0) begin
            mosi_pin = 1'b0;
            return;
        end
        // word size and bit order are read live, positions wrap at 32
        idx = cfg_lsb ? xfer_bits() - bits_left : bits_left - CNT_BITS'(1);
        mosi_pin = tx_sr[idx[POS_BITS-1:0]];
    endfunction

    function automatic void capture_miso(logic b);
        logic [CNT_BITS-1:0] pos;
        if (!xfer_dir[1]) begin
            return;
        end
        pos = cfg_lsb ? CNT_BITS'(32) - bits_left
                      : CNT_BITS'(63) - xfer_bits() + bits_left;
        rx_sr[pos[POS_BITS-1:0]] = b;
    endfunction

    function automatic void quarter_tick(logic miso);
        logic early;
        early = (cfg_mode == 2'd0 || cfg_mode == 2'd3);
        // a count at or above a lowered divider still ends the quarter
        if (pre_cnt < cfg_div) begin
            pre_cnt = pre_cnt + DIV_BITS'(1);
            return;
        end
        pre_cnt = '0;
        qtr = t_quarter'(qtr + 2'd1);
        case (qtr)
            QTR_1: begin
                sclk_pin = ~cfg_mode[1];
                if (early) capture_miso(miso);
            end
            QTR_3: begin
                sclk_pin = cfg_mode[1];
                if (!early) capture_miso(miso);
            end
            QTR_0: begin
                bits_left = bits_left - CNT_BITS'(1);
                if (bits_left == '0) begin
                    busy = 1'b0;
                    mosi_pin = 1'b0;
                    if (cfg_irq_en) irq_pend = 1'b1;
                end else begin
                    pick_mosi();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_result spi_next_pins(t_spi_cmd c);
        t_result r;
        logic    was_busy;
        was_busy = busy;
        if (c.op == OP_CLR_IRQ) irq_pend = 1'b0;
        else if (c.op == OP_SET_CS) cs_pin = c.cs;
        if (was_busy) begin
            quarter_tick(c.miso);
        end else begin
            sclk_pin = cfg_mode[1];
            if (c.op == OP_START && cfg_en) begin
                tx_sr     = c.tx;
                rx_sr     = '0;
                xfer_dir  = c.dir;
                bits_left = xfer_bits();
                pre_cnt   = '0;
                qtr       = QTR_0;
                busy      = 1'b1;
                pick_mosi();
            end
        end
        r.sclk_level = sclk_pin;
        r.mosi_level = mosi_pin;
        r.cs_out     = cs_pin;
        r.busy_res   = busy;
        r.rx_word    = rx_sr;
        r.irq_flag   = irq_pend;
        return r;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_WORD_SIZE:  cfg_ws     = data[1:0];
            CFG_LSB_FIRST:  cfg_lsb    = data[0];
            CFG_CLK_DIV:    cfg_div    = data[DIV_BITS-1:0];
            CFG_CLK_MODE:   cfg_mode   = data[1:0];
            CFG_ENABLE:     cfg_en     = data[0];
            CFG_IRQ_ENABLE: cfg_irq_en = data[0];
            default: ;
        endcase
    endfunction

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_op rand_op(bit allow_start);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return OP_TICK;
        if (r < 88) return OP_SET_CS;
        if (r < 96) return OP_CLR_IRQ;
        return allow_start ? OP_START : OP_TICK;
    endfunction

    function automatic t_spi_cmd make_cmd(t_op op);
        t_spi_cmd c;
        c.op   = op;
        c.dir  = 2'($urandom);
        c.tx   = $urandom;
        c.cs   = 1'($urandom);
        c.miso = 1'($urandom);
        return c;
    endfunction

    function automatic void push_cmd(t_spi_cmd c);
        cmd_q.push_back(c);
        queued_count++;
    endfunction

    function automatic int xfer_ticks();
        return cfg_en ? int'(xfer_bits()) * 4 * (int'(cfg_div) + 1) : 6;
    endfunction

    function automatic void queue_transfer(logic [1:0] dir, logic [WORD_BITS-1:0] tx,
                                           int ticks, bit noisy);
        t_spi_cmd c;
        c     = make_cmd(OP_START);
        c.dir = dir;
        c.tx  = tx;
        push_cmd(c);
        for (int k = 0; k < ticks; k++) begin
            push_cmd(make_cmd(noisy ? rand_op(1'b1) : OP_TICK));
        end
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_count < MAX_PRINTS) begin
            $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // upper data bits beyond a register's width carry junk
    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        logic [CFG_DATA_BITS-1:0] data;
        data = val;
        case (idx)
            CFG_WORD_SIZE, CFG_CLK_MODE: data = {14'($urandom), val[1:0]};
            CFG_LSB_FIRST, CFG_ENABLE, CFG_IRQ_ENABLE: data = {15'($urandom), val[0]};
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_cfg(idx, data);
    endtask

    task automatic cfg_write_all(logic [1:0] ws, logic lsb, logic [DIV_BITS-1:0] div,
                                 logic [1:0] mode, logic en, logic irq_en);
        cfg_write(CFG_WORD_SIZE, 16'(ws));
        cfg_write(CFG_LSB_FIRST, 16'(lsb));
        cfg_write(CFG_CLK_DIV, div);
        cfg_write(CFG_CLK_MODE, 16'(mode));
        cfg_write(CFG_ENABLE, 16'(en));
        cfg_write(CFG_IRQ_ENABLE, 16'(irq_en));
    endtask

    // wait until every queued transaction has come back
    task automatic drain();
        while (cmd_q.size() != 0 || pin_expect_q.size() != 0 || i_in_valid) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pin_expect_q.push_back(spi_next_pins(cur_cmd));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_in_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cur_cmd = cmd_q.pop_front();
                    i_operation <= cur_cmd.op;
                    i_direction <= cur_cmd.dir;
                    i_tx_word   <= cur_cmd.tx;
                    i_cs_level  <= cur_cmd.cs;
                    i_miso_bit  <= cur_cmd.miso;
                    i_in_valid  <= 1'b1;
                    drv_gap = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pin_expect_q.size() == 0) begin
                    report_mismatch("result with no transaction pending");
                end else begin
                    want_pins = pin_expect_q.pop_front();
                    check_field("sclk", 32'(o_sclk_level), 32'(want_pins.sclk_level));
                    check_field("mosi", 32'(o_mosi_level), 32'(want_pins.mosi_level));
                    check_field("cs", 32'(o_cs_out), 32'(want_pins.cs_out));
                    check_field("busy", 32'(o_busy_res), 32'(want_pins.busy_res));
                    check_field("rx_word", o_rx_word, want_pins.rx_word);
                    check_field("irq", 32'(o_irq_flag), 32'(want_pins.irq_flag));
                end
                // one long hold so the output buffer fills and the input backs up
                if (!held && results_seen >= HOLD_AT && cmd_q.size() > 8) begin
                    hold_left = HOLD_CYCLES;
                    held      = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rcv_gap > 0) begin
                rcv_gap--;
                i_out_stall <= 1'b1;
            end else begin
                rcv_gap = pick_gap();
                i_out_stall <= (rcv_gap != 0);
                if (rcv_gap != 0) rcv_gap--;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int          base;
        int          r;
        int          ticks;
        logic [1:0]  ws;
        logic [15:0] div;
        logic [1:0]  dir;

        pins_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled block: start ignored, chip select and irq clear still work
        push_cmd(make_cmd(OP_START));
        begin
            t_spi_cmd c;
            c = make_cmd(OP_SET_CS); c.cs = 1'b0; push_cmd(c);
            c = make_cmd(OP_SET_CS); c.cs = 1'b1; push_cmd(c);
        end
        push_cmd(make_cmd(OP_CLR_IRQ));
        push_cmd(make_cmd(OP_TICK));
        drain();
        cfg_write(CFG_SPARE_A, 16'($urandom));
        cfg_write(CFG_SPARE_B, 16'($urandom));

        // full write+read byte, a start while busy, completion lands on an irq clear
        cfg_write_all(2'd0, 1'b0, 16'd0, 2'd0, 1'b1, 1'b1);
        queue_transfer(DIR_BOTH, 32'hFFFF_FFFF, 0, 1'b0);
        push_cmd(make_cmd(OP_START));
        repeat (30) push_cmd(make_cmd(OP_TICK));
        push_cmd(make_cmd(OP_CLR_IRQ));
        push_cmd(make_cmd(OP_TICK));
        push_cmd(make_cmd(OP_CLR_IRQ));
        drain();

        // slowest divider, then settings changed mid transfer
        cfg_write_all(2'd0, 1'b0, 16'hFFFF, 2'd2, 1'b1, 1'b1);
        queue_transfer(DIR_BOTH, 32'h8000_00A5, 6, 1'b0);
        drain();
        cfg_write(CFG_CLK_DIV, 16'd1);
        cfg_write(CFG_ENABLE, 16'd0);
        cfg_write(CFG_WORD_SIZE, 16'd3);
        cfg_write(CFG_LSB_FIRST, 16'd1);
        cfg_write(CFG_IRQ_ENABLE, 16'd0);
        repeat (70) push_cmd(make_cmd(OP_TICK));
        drain();

        // no direction: clocks run, nothing driven or received
        cfg_write_all(2'd0, 1'b1, 16'd0, 2'd1, 1'b1, 1'b1);
        queue_transfer(DIR_NONE, 32'hFFFF_FFFF, xfer_ticks() + 2, 1'b0);
        drain();

        base = queued_count;
        while (queued_count - base < RANDOM_ITEMS) begin
            r  = $urandom_range(0, 99);
            ws = (r < 50) ? 2'd0 : (r < 70) ? 2'd1 : (r < 85) ? 2'd2 : 2'd3;
            r  = $urandom_range(0, 99);
            div = (r < 65) ? 16'd0 : (r < 85) ? 16'd1 : 16'($urandom_range(2, 4));
            if (ws >= 2'd2 && div > 16'd1) div = 16'd1;
            no_idle = ($urandom_range(0, 99) < 25);
            cfg_write_all(ws, 1'($urandom), div, 2'($urandom),
                          ($urandom_range(0, 99) < 90), 1'($urandom));
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 3)) push_cmd(make_cmd(rand_op(1'b0)));
                dir = ($urandom_range(0, 99) < 10) ? DIR_NONE : 2'($urandom_range(1, 3));
                // some transfers are cut short and run on under the next settings
                if ($urandom_range(0, 99) < 15) ticks = $urandom_range(1, xfer_ticks());
                else ticks = xfer_ticks() + $urandom_range(0, 4);
                queue_transfer(dir, $urandom, ticks, ($urandom_range(0, 99) < 70));
            end
            drain();
        end

        no_idle = 1'b0;
        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
